// ===== rtl/core/ppd_pkg.sv =====
// Package with the shared types and constants of the port packet deframer.
package ppd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ReasonW  = 2;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [ByteW-1:0] HeaderBytes = 8'd3;
  localparam logic [ByteW-1:0] ResetStart  = 8'hFC;
  localparam logic [ByteW-1:0] ResetEnd    = 8'hFB;
  localparam logic [ByteW-1:0] ResetPorts  = 8'd8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStartByte = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEndByte   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPortCount = 2'd2;

  // Result kinds.
  localparam logic [KindW-1:0] KindPayload = 2'd0;
  localparam logic [KindW-1:0] KindAccept  = 2'd1;
  localparam logic [KindW-1:0] KindDrop    = 2'd2;

  // Drop reasons.
  localparam logic [ReasonW-1:0] ReasonNone     = 2'd0;
  localparam logic [ReasonW-1:0] ReasonBadDest  = 2'd1;
  localparam logic [ReasonW-1:0] ReasonChecksum = 2'd2;
  localparam logic [ReasonW-1:0] ReasonBadLen   = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] end_byte;
    logic [ByteW-1:0] port_count;
  } cfg_t;

  typedef struct packed {
    logic [ReasonW-1:0] drop_reason;
    logic [ByteW-1:0]   payload_length;
    logic [ByteW-1:0]   dest_port;
    logic [ByteW-1:0]   source_port;
    logic [ByteW-1:0]   byte_index;
    logic [ByteW-1:0]   payload_byte;
    logic [KindW-1:0]   result_kind;
  } result_t;

endpackage

// ===== rtl/core/ppd_cfg_regs.sv =====
// Configuration registers of the port packet deframer.
module ppd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ppd_pkg::ByteW-1:0]     cfg_data_i,
  output ppd_pkg::cfg_t                 cfg_o
);

  ppd_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ppd_pkg::CfgStartByte: cfg_d.start_byte = cfg_data_i;
        ppd_pkg::CfgEndByte:   cfg_d.end_byte   = cfg_data_i;
        ppd_pkg::CfgPortCount: cfg_d.port_count = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= ppd_pkg::ResetStart;
      cfg_q.end_byte   <= ppd_pkg::ResetEnd;
      cfg_q.port_count <= ppd_pkg::ResetPorts;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/ppd_parser.sv =====
// Frame parser: phase state, header fields, running checksum and per-byte result.
module ppd_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ppd_pkg::cfg_t             cfg_i,
  input  logic                      fire_i,
  input  logic [ppd_pkg::ByteW-1:0] rx_byte_i,
  output logic                      res_valid_o,
  output ppd_pkg::result_t          res_o
);

  typedef enum logic [2:0] {
    PhWait = 3'd0,
    PhLen  = 3'd1,
    PhSrc  = 3'd2,
    PhDst  = 3'd3,
    PhData = 3'd4,
    PhSum  = 3'd5,
    PhEnd  = 3'd6
  } phase_e;

  phase_e                   phase_d, phase_q;
  logic [ppd_pkg::ByteW-1:0] exp_len_d, exp_len_q;
  logic [ppd_pkg::ByteW-1:0] rcv_cnt_d, rcv_cnt_q;
  logic [ppd_pkg::ByteW-1:0] sum_d, sum_q;
  logic [ppd_pkg::ByteW-1:0] src_d, src_q;
  logic [ppd_pkg::ByteW-1:0] dst_d, dst_q;
  logic [ppd_pkg::ByteW-1:0] sum_add;

  assign sum_add = sum_q + rx_byte_i;

  always_comb begin
    phase_d     = phase_q;
    exp_len_d   = exp_len_q;
    rcv_cnt_d   = rcv_cnt_q;
    sum_d       = sum_q;
    src_d       = src_q;
    dst_d       = dst_q;
    res_valid_o = 1'b0;
    res_o.result_kind    = ppd_pkg::KindPayload;
    res_o.payload_byte   = '0;
    res_o.byte_index     = '0;
    res_o.payload_length = exp_len_q;
    res_o.drop_reason    = ppd_pkg::ReasonNone;

    case (phase_q)
      PhLen: begin
        src_d     = '0;
        dst_d     = '0;
        rcv_cnt_d = '0;
        if (rx_byte_i < ppd_pkg::HeaderBytes) begin
          exp_len_d   = '0;
          sum_d       = '0;
          phase_d     = PhWait;
          res_valid_o = 1'b1;
          res_o.result_kind    = ppd_pkg::KindDrop;
          res_o.payload_length = '0;
          res_o.drop_reason    = ppd_pkg::ReasonBadLen;
        end else begin
          exp_len_d = rx_byte_i - ppd_pkg::HeaderBytes;
          sum_d     = rx_byte_i;
          phase_d   = PhSrc;
        end
      end
      PhSrc: begin
        src_d   = rx_byte_i;
        sum_d   = sum_add;
        phase_d = PhDst;
      end
      PhDst: begin
        dst_d = rx_byte_i;
        sum_d = sum_add;
        if (rx_byte_i >= cfg_i.port_count) begin
          phase_d     = PhWait;
          res_valid_o = 1'b1;
          res_o.result_kind = ppd_pkg::KindDrop;
          res_o.drop_reason = ppd_pkg::ReasonBadDest;
        end else if (exp_len_q == '0) begin
          phase_d = PhSum;
        end else begin
          phase_d = PhData;
        end
      end
      PhData: begin
        sum_d     = sum_add;
        rcv_cnt_d = rcv_cnt_q + 8'd1;
        if (rcv_cnt_d == exp_len_q) begin
          phase_d = PhSum;
        end
        res_valid_o = 1'b1;
        res_o.payload_byte = rx_byte_i;
        res_o.byte_index   = rcv_cnt_q;
      end
      PhSum: begin
        if (rx_byte_i != sum_q) begin
          phase_d     = PhWait;
          res_valid_o = 1'b1;
          res_o.result_kind = ppd_pkg::KindDrop;
          res_o.drop_reason = ppd_pkg::ReasonChecksum;
        end else begin
          phase_d = PhEnd;
        end
      end
      PhEnd: begin
        // Anything other than the end byte is skipped while the frame closes.
        if (rx_byte_i == cfg_i.end_byte) begin
          phase_d     = PhWait;
          res_valid_o = 1'b1;
          res_o.result_kind = ppd_pkg::KindAccept;
        end
      end
      default: begin
        phase_d = (rx_byte_i == cfg_i.start_byte) ? PhLen : PhWait;
      end
    endcase

    // The header fields reported are those after this byte's update.
    res_o.source_port = src_d;
    res_o.dest_port   = dst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhWait;
      exp_len_q <= '0;
      rcv_cnt_q <= '0;
      sum_q     <= '0;
      src_q     <= '0;
      dst_q     <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      exp_len_q <= exp_len_d;
      rcv_cnt_q <= rcv_cnt_d;
      sum_q     <= sum_d;
      src_q     <= src_d;
      dst_q     <= dst_d;
    end
  end

endmodule

// ===== rtl/core/ppd_out_reg.sv =====
// Result register that holds one beat until the downstream side takes it.
module ppd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ppd_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             can_load_o,
  output logic             valid_o,
  output ppd_pkg::result_t res_o
);

  logic             valid_d, valid_q;
  ppd_pkg::result_t res_q;

  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/core/port_packet_deframer_top.sv =====
// Top level of the port packet deframer: input register, parser and result register.
//
// The block takes one received byte per beat and parses frames of start byte, length
// (payload count plus three), source port, destination port, payload, 8-bit additive
// checksum and end byte. Each payload byte comes out as a beat of its own, a frame
// that closes cleanly gives an accept beat, and a bad length, bad destination or
// checksum mismatch gives a drop beat; other bytes give no beat. One byte is taken
// every cycle while the result side is ready; a byte is registered on entry, and when
// it leaves the input register the parser state and the result register are updated
// together. A result that waits on the downstream side stalls the input once the input
// register is also full. The configuration registers should only be written while no
// byte is in flight.
module port_packet_deframer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ppd_pkg::ByteW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] rx_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] payload_byte, [15:8] byte_index, [23:16] source_port, [31:24] dest_port,
  // [39:32] payload_length, [41:40] drop_reason, [47:42] zero
  output logic [47:0]                   m_axis_tdata_o,
  output logic [1:0]                    m_axis_tuser_o   // [1:0] result_kind
);

  ppd_pkg::cfg_t             cfg;
  ppd_pkg::result_t          par_res;
  ppd_pkg::result_t          out_res;
  logic                      par_valid;
  logic                      can_load;
  logic                      advance;
  logic                      in_valid_d, in_valid_q;
  logic [ppd_pkg::ByteW-1:0] in_byte_q;
  logic                      s_accept;

  ppd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // A byte leaves the input register only when the result register can take a beat.
  assign advance         = in_valid_q && can_load;
  assign s_axis_tready_o = !in_valid_q || can_load;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  ppd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (advance),
    .rx_byte_i   (in_byte_q),
    .res_valid_o (par_valid),
    .res_o       (par_res)
  );

  ppd_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (advance && par_valid),
    .res_i      (par_res),
    .ready_i    (m_axis_tready_i),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid_o),
    .res_o      (out_res)
  );

  assign m_axis_tuser_o = out_res.result_kind;
  assign m_axis_tdata_o = {6'd0, out_res.drop_reason, out_res.payload_length,
                           out_res.dest_port, out_res.source_port,
                           out_res.byte_index, out_res.payload_byte};

`ifndef ASSERT_OFF
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input not ready while result register is empty");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ppd_pkg::KindPayload ||
                         m_axis_tuser_o == ppd_pkg::KindAccept ||
                         m_axis_tuser_o == ppd_pkg::KindDrop))
    else $error("illegal result kind");

  a_drop_has_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == ppd_pkg::KindDrop) |->
      m_axis_tdata_o[41:40] != ppd_pkg::ReasonNone)
    else $error("drop beat without a reason");

  a_keep_has_no_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ppd_pkg::KindDrop) |->
      m_axis_tdata_o[41:40] == ppd_pkg::ReasonNone)
    else $error("drop reason set on a non-drop beat");
`endif

endmodule

// ===== tb/port_packet_deframer_top_test.sv =====
// Self-checking testbench for the port packet deframer top level.
`timescale 1ns / 1ps

module port_packet_deframer_top_test;
  import ppd_pkg::*;

  localparam int unsigned ClkPeriod   = 4;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 320;
  localparam int unsigned IdlePct     = 19;
  localparam int unsigned MaxPayload  = 252;

  typedef enum logic [2:0] {
    ParseWait, ParseLen, ParseSrc, ParseDst, ParseData, ParseSum, ParseEnd
  } parse_phase_e;

  class deframer_scoreboard;
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] end_byte;
    logic [ByteW-1:0] port_count;
    parse_phase_e     phase;
    logic [ByteW-1:0] exp_len;
    logic [ByteW-1:0] rx_count;
    logic [ByteW-1:0] csum;
    logic [ByteW-1:0] src;
    logic [ByteW-1:0] dst;
    result_t          result_beats[$];
    int unsigned      errors;

    function new();
      start_byte = ResetStart;
      end_byte   = ResetEnd;
      port_count = ResetPorts;
      phase      = ParseWait;
      exp_len    = '0;
      rx_count   = '0;
      csum       = '0;
      src        = '0;
      dst        = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        CfgStartByte: start_byte = val;
        CfgEndByte:   end_byte   = val;
        CfgPortCount: port_count = val;
        default: ;
      endcase
    endfunction

    function void push_result(logic [KindW-1:0] kind, logic [ByteW-1:0] pbyte,
                              logic [ByteW-1:0] idx, logic [ByteW-1:0] len,
                              logic [ReasonW-1:0] reason);
      result_t r;
      r.result_kind    = kind;
      r.payload_byte   = pbyte;
      r.byte_index     = idx;
      r.source_port    = src;
      r.dest_port      = dst;
      r.payload_length = len;
      r.drop_reason    = reason;
      result_beats.push_back(r);
    endfunction

    // Advances the frame parser by one received byte.
    function void note_rx_byte(logic [ByteW-1:0] c);
      logic [ByteW-1:0] idx;
      case (phase)
        ParseLen: begin
          src      = '0;
          dst      = '0;
          rx_count = '0;
          if (c < HeaderBytes) begin
            exp_len = '0;
            csum    = '0;
            phase   = ParseWait;
            push_result(KindDrop, '0, '0, '0, ReasonBadLen);
          end else begin
            exp_len = c - HeaderBytes;
            csum    = c;
            phase   = ParseSrc;
          end
        end
        ParseSrc: begin
          src   = c;
          csum  = csum + c;
          phase = ParseDst;
        end
        ParseDst: begin
          dst  = c;
          csum = csum + c;
          if (c >= port_count) begin
            phase = ParseWait;
            push_result(KindDrop, '0, '0, exp_len, ReasonBadDest);
          end else if (exp_len == '0) begin
            phase = ParseSum;
          end else begin
            phase = ParseData;
          end
        end
        ParseData: begin
          idx      = rx_count;
          csum     = csum + c;
          rx_count = rx_count + 8'd1;
          if (rx_count == exp_len) phase = ParseSum;
          push_result(KindPayload, c, idx, exp_len, ReasonNone);
        end
        ParseSum: begin
          if (c != csum) begin
            phase = ParseWait;
            push_result(KindDrop, '0, '0, exp_len, ReasonChecksum);
          end else begin
            phase = ParseEnd;
          end
        end
        ParseEnd: begin
          // Anything but the end byte is skipped here.
          if (c == end_byte) begin
            phase = ParseWait;
            push_result(KindAccept, '0, '0, exp_len, ReasonNone);
          end
        end
        default: begin
          phase = (c == start_byte) ? ParseLen : ParseWait;
        end
      endcase
    endfunction

    function void compare(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result_beat(logic [47:0] data, logic [KindW-1:0] kind);
      result_t e;
      if (result_beats.size() == 0) begin
        $error("unexpected result beat: tuser %0d, tdata %h", kind, data);
        errors++;
        return;
      end
      e = result_beats.pop_front();
      compare("result_kind",    e.result_kind,    kind);
      compare("payload_byte",   e.payload_byte,   data[7:0]);
      compare("byte_index",     e.byte_index,     data[15:8]);
      compare("source_port",    e.source_port,    data[23:16]);
      compare("dest_port",      e.dest_port,      data[31:24]);
      compare("payload_length", e.payload_length, data[39:32]);
      compare("drop_reason",    e.drop_reason,    data[41:40]);
      compare("tdata_padding",  0,                data[47:42]);
    endfunction

    function int unsigned pending();
      return result_beats.size();
    endfunction
  endclass

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                cfg_we        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx       = CfgStartByte;
  logic [ByteW-1:0]    cfg_data      = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [47:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  deframer_scoreboard  sb = new();
  logic [ByteW-1:0]    frame_q[$];
  int unsigned         sent_count  = 0;
  int unsigned         tx_idle_pct = IdlePct;
  int unsigned         rx_idle_pct = IdlePct;
  int unsigned         hold_left   = 0;
  int unsigned         quiet_cycles = 0;
  bit                  hold_req    = 1'b0;
  bit                  drain       = 1'b0;

  port_packet_deframer_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Result side: checks each beat and drives tready, with an occasional long hold-off.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result_beat(m_axis_tdata, m_axis_tuser);
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) hold_left--;
    m_axis_tready <= drain || (hold_left == 0 && $urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_rx_byte(b);
    sent_count++;
  endtask

  task automatic send_frames();
    foreach (frame_q[i]) send_byte(frame_q[i]);
    frame_q.delete();
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Registers change only once the parser has gone quiet.
  task automatic write_config(input logic [ByteW-1:0] sb_start, input logic [ByteW-1:0] sb_end,
                              input logic [ByteW-1:0] ports);
    s_axis_tvalid <= 1'b0;
    drain = 1'b1;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    write_reg(CfgStartByte, sb_start);
    write_reg(CfgEndByte, sb_end);
    write_reg(CfgPortCount, ports);
    cfg_we <= 1'b0;
    drain = 1'b0;
  endtask

  // Queues one frame, mostly well formed; a negative size picks one at random.
  function automatic void build_frame(input int forced_len);
    int unsigned      sel;
    int unsigned      plen;
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] src;
    logic [ByteW-1:0] dst;
    logic [ByteW-1:0] csum;
    logic [ByteW-1:0] b;
    sel = $urandom_range(99);
    if (forced_len < 0 && sel < 8) begin
      repeat ($urandom_range(6, 1)) frame_q.push_back(8'($urandom));
      return;
    end
    frame_q.push_back(sb.start_byte);
    if (forced_len < 0 && sel < 13) begin
      frame_q.push_back(8'($urandom_range(2)));
      return;
    end
    if (forced_len >= 0) plen = forced_len;
    else if ($urandom_range(99) == 0) plen = $urandom_range(1) ? MaxPayload : $urandom_range(251, 100);
    else plen = $urandom_range(12);
    len = 8'(plen + 3);
    src = 8'($urandom);
    if (sb.port_count == 0 || $urandom_range(99) < 12) dst = 8'($urandom_range(255, sb.port_count));
    else dst = 8'($urandom_range(sb.port_count - 1, 0));
    frame_q.push_back(len);
    frame_q.push_back(src);
    frame_q.push_back(dst);
    csum = len + src + dst;
    if (dst >= sb.port_count && $urandom_range(1) == 0) return;
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom);
      csum = csum + b;
      frame_q.push_back(b);
    end
    if ($urandom_range(99) < 3) return;
    if ($urandom_range(99) < 10) csum = csum ^ 8'($urandom_range(255, 1));
    frame_q.push_back(csum);
    if ($urandom_range(9) >= 7) begin
      repeat ($urandom_range(3, 1)) begin
        b = 8'($urandom);
        if (b == sb.end_byte) b = b ^ 8'h01;
        frame_q.push_back(b);
      end
    end
    frame_q.push_back(sb.end_byte);
  endfunction

  task automatic run_random(input int unsigned items);
    int unsigned target;
    target = sent_count + items;
    while (sent_count < target) begin
      build_frame(-1);
      send_frames();
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: noise, empty payload, payload with a start byte as source and
    // skipped bytes before the end, bad length, bad destination, checksum mismatch.
    frame_q = '{8'h00, ResetEnd,
                ResetStart, 8'h03, 8'h00, 8'h00, 8'h03, ResetEnd,
                ResetStart, 8'h05, ResetStart, 8'h07, 8'h00, 8'hFF, 8'h07, 8'h12,
                ResetStart, ResetEnd,
                ResetStart, 8'h00,
                ResetStart, 8'h03, 8'h01, 8'h08,
                ResetStart, 8'h03, 8'h01, 8'h01, 8'h00};
    send_frames();
    build_frame(MaxPayload);
    send_frames();
    run_random(PhaseItems);

    write_config(8'h00, 8'hFF, 8'd255);
    run_random(PhaseItems);

    write_config(8'hFF, 8'h00, 8'd1);
    hold_req = 1'b1;
    run_random(PhaseItems);

    write_config(8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(PhaseItems);
    tx_idle_pct = IdlePct;
    rx_idle_pct = IdlePct;

    // Every destination is out of range with no ports.
    write_config(8'h7E, 8'h7E, 8'd0);
    run_random(PhaseItems / 4);

    write_config(8'($urandom), 8'($urandom), 8'($urandom_range(16, 1)));
    run_random(PhaseItems);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
